@@ sv/mandelbrot_escape_time_pixel_macros.svh @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/met_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: package
// Widths, register codes, controller types and fixed-point helpers.
// ----------------------------------------------------------------------------
package met_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_W     = 28;
	localparam int PIX_W      = 12;
	localparam int ITER_W     = 12;
	localparam int STEP_W     = 31;
	localparam int LIMIT_W    = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int MAP_PROD_W = PIX_W + STEP_W;
	localparam int SQ_PROD_W  = 2 * COORD_W;
	localparam int SQ_W       = SQ_PROD_W - FRAC_W;
	localparam int XY2_W      = SQ_PROD_W - FRAC_W + 1;
	localparam int SAT_IN_W   = MAP_PROD_W + 3;

	localparam logic signed [SAT_IN_W-1:0] SAT_HI =
		SAT_IN_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [SAT_IN_W-1:0] SAT_LO = ~SAT_HI;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_RE,
		CFG_ORIGIN_IM,
		CFG_PIXEL_STEP,
		CFG_MAX_ITER,
		CFG_ESCAPE_LIMIT
	} cfg_idx_t;

	localparam coord_t              RST_ORIGIN_RE    = coord_t'(-32'sd536870912);
	localparam coord_t              RST_ORIGIN_IM    = coord_t'(-32'sd536870912);
	localparam logic [STEP_W-1:0]   RST_PIXEL_STEP   = STEP_W'(262144);
	localparam logic [ITER_W-1:0]   RST_MAX_ITER     = ITER_W'(250);
	localparam logic [LIMIT_W-1:0]  RST_ESCAPE_LIMIT = LIMIT_W'(1073741824);

	typedef struct packed {
		coord_t              origin_re;
		coord_t              origin_im;
		logic [STEP_W-1:0]   pixel_step;
		logic [ITER_W-1:0]   max_iter;
		logic [LIMIT_W-1:0]  escape_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP_ADD,
		ST_SQUARE,
		ST_EVAL,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic load_in;
		logic map_add;
		logic square;
		logic update;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	// Positions beyond the frame are pulled back onto its last column or row.
	function automatic logic [PIX_W-1:0] clamp_pix(input logic [PIX_W-1:0] p, input int lim);
		logic [PIX_W-1:0] r;
		r = p;
		if (int'(p) >= lim) begin
			r = PIX_W'(lim - 1);
		end
		return r;
	endfunction

	function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
		coord_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ sv/met_if.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: channel interfaces
// Valid/ready channels for pixel positions and escape results.
// ----------------------------------------------------------------------------
interface met_pix_if;
	import met_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface met_res_if;
	import met_pkg::*;

	logic              valid;
	logic              ready;
	logic [ITER_W-1:0] iterations;
	logic              inside_res;

	modport source (output valid, output iterations, output inside_res, input ready);
	modport sink (input valid, input iterations, input inside_res, output ready);
endinterface

@@ sv/met_cfg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: configuration registers
// Holds the plane mapping, iteration limit and escape bound.
// ----------------------------------------------------------------------------
module met_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [met_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0] cfg_data,
	output met_pkg::cfg_t                 cfg
);
	import met_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_re    <= RST_ORIGIN_RE;
			cfg_q.origin_im    <= RST_ORIGIN_IM;
			cfg_q.pixel_step   <= RST_PIXEL_STEP;
			cfg_q.max_iter     <= RST_MAX_ITER;
			cfg_q.escape_limit <= RST_ESCAPE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_RE:    cfg_q.origin_re    <= cfg_data[COORD_W-1:0];
				CFG_ORIGIN_IM:    cfg_q.origin_im    <= cfg_data[COORD_W-1:0];
				CFG_PIXEL_STEP:   cfg_q.pixel_step   <= cfg_data[STEP_W-1:0];
				CFG_MAX_ITER:     cfg_q.max_iter     <= cfg_data[ITER_W-1:0];
				CFG_ESCAPE_LIMIT: cfg_q.escape_limit <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

@@ sv/met_ctrl.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: controller
// Sequences mapping, squaring and evaluation, and owns the output valid.
// ----------------------------------------------------------------------------
module met_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  met_pkg::sts_t sts,
	output met_pkg::cmd_t cmd
);
	import met_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MAP_ADD;
				end
			end
			ST_MAP_ADD: begin
				cmd.map_add = 1'b1;
				state_d     = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.done) begin
					cmd.finish = 1'b1;
					state_d    = ST_HOLD;
				end else begin
					cmd.update = 1'b1;
					state_d    = ST_SQUARE;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

@@ sv/met_dp.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: datapath
// Maps a pixel to c, iterates z = z^2 + c and forms the escape result.
// ----------------------------------------------------------------------------
module met_dp (
	input  logic                       clk,
	input  met_pkg::cfg_t              cfg,
	input  met_pkg::cmd_t              cmd,
	output met_pkg::sts_t              sts,
	input  logic [met_pkg::PIX_W-1:0]  pixel_x,
	input  logic [met_pkg::PIX_W-1:0]  pixel_y,
	output logic [met_pkg::ITER_W-1:0] iterations,
	output logic                       inside_res
);
	import met_pkg::*;

	logic [MAP_PROD_W-1:0]       map_x_q;
	logic [MAP_PROD_W-1:0]       map_y_q;
	coord_t                      c_re_q;
	coord_t                      c_im_q;
	coord_t                      z_re_q;
	coord_t                      z_im_q;
	logic [ITER_W-1:0]           idx_q;
	logic signed [SQ_PROD_W-1:0] p_rr_q;
	logic signed [SQ_PROD_W-1:0] p_ii_q;
	logic signed [SQ_PROD_W-1:0] p_ri_q;
	logic [ITER_W-1:0]           res_iter_q;
	logic                        res_inside_q;
	logic [ITER_W-1:0]           out_iter_q;
	logic                        out_inside_q;

	logic [PIX_W-1:0]            px_cl;
	logic [PIX_W-1:0]            py_cl;
	logic signed [SAT_IN_W-1:0]  map_re_sum;
	logic signed [SAT_IN_W-1:0]  map_im_sum;
	logic [SQ_W-1:0]             xx;
	logic [SQ_W-1:0]             yy;
	logic signed [XY2_W-1:0]     xy2;
	logic [SQ_W:0]               mag;
	logic signed [SAT_IN_W-1:0]  new_re_sum;
	logic signed [SAT_IN_W-1:0]  new_im_sum;
	logic                        escaped;
	logic                        hit_zero;
	logic                        hit_limit;

	always_comb begin
		px_cl = clamp_pix(pixel_x, MAX_WIDTH);
		py_cl = clamp_pix(pixel_y, MAX_HEIGHT);

		map_re_sum = {{(SAT_IN_W-COORD_W){cfg.origin_re[COORD_W-1]}}, cfg.origin_re}
			+ {{(SAT_IN_W-MAP_PROD_W){1'b0}}, map_x_q};
		map_im_sum = {{(SAT_IN_W-COORD_W){cfg.origin_im[COORD_W-1]}}, cfg.origin_im}
			+ {{(SAT_IN_W-MAP_PROD_W){1'b0}}, map_y_q};

		// Squares are never negative; the cross term keeps its sign.
		xx  = p_rr_q[SQ_PROD_W-1:FRAC_W];
		yy  = p_ii_q[SQ_PROD_W-1:FRAC_W];
		xy2 = p_ri_q[SQ_PROD_W-1:FRAC_W-1];
		mag = {1'b0, xx} + {1'b0, yy};

		new_re_sum = {{(SAT_IN_W-SQ_W){1'b0}}, xx} - {{(SAT_IN_W-SQ_W){1'b0}}, yy}
			+ {{(SAT_IN_W-COORD_W){c_re_q[COORD_W-1]}}, c_re_q};
		new_im_sum = {{(SAT_IN_W-XY2_W){xy2[XY2_W-1]}}, xy2}
			+ {{(SAT_IN_W-COORD_W){c_im_q[COORD_W-1]}}, c_im_q};

		// The starting point is not tested for escape or zero, only values after an update.
		escaped   = (idx_q != '0) && (mag > (SQ_W+1)'(cfg.escape_limit));
		hit_zero  = (idx_q != '0) && (z_re_q == '0) && (z_im_q == '0);
		hit_limit = (idx_q == cfg.max_iter);
		sts.done  = escaped || hit_zero || hit_limit;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			map_x_q <= MAP_PROD_W'(px_cl) * MAP_PROD_W'(cfg.pixel_step);
			map_y_q <= MAP_PROD_W'(py_cl) * MAP_PROD_W'(cfg.pixel_step);
		end
		if (cmd.map_add) begin
			c_re_q <= sat_coord(map_re_sum);
			c_im_q <= sat_coord(map_im_sum);
			z_re_q <= sat_coord(map_re_sum);
			z_im_q <= sat_coord(map_im_sum);
			idx_q  <= '0;
		end
		if (cmd.square) begin
			p_rr_q <= SQ_PROD_W'(z_re_q) * SQ_PROD_W'(z_re_q);
			p_ii_q <= SQ_PROD_W'(z_im_q) * SQ_PROD_W'(z_im_q);
			p_ri_q <= SQ_PROD_W'(z_re_q) * SQ_PROD_W'(z_im_q);
		end
		if (cmd.update) begin
			z_re_q <= sat_coord(new_re_sum);
			z_im_q <= sat_coord(new_im_sum);
			idx_q  <= idx_q + ITER_W'(1);
		end
		if (cmd.finish) begin
			res_iter_q   <= escaped ? idx_q - ITER_W'(1) : cfg.max_iter;
			res_inside_q <= !escaped;
		end
		if (cmd.out_load) begin
			out_iter_q   <= res_iter_q;
			out_inside_q <= res_inside_q;
		end
	end

	assign iterations = out_iter_q;
	assign inside_res = out_inside_q;
endmodule

@@ sv/mandelbrot_escape_time_pixel.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel engine
// Maps a pixel to a point of the plane and counts iterations to escape.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// pixel     in         pixel_x[11:0], pixel_y[11:0]
// result    out        iterations[11:0], inside_res
// cfg       in         cfg_we, cfg_index[2:0], cfg_data[31:0]
//
// An accepted item has its pixel products registered, then the plane mapping
// forms c and the start value; each update then takes a multiplier state for
// the three products and an add, saturate and compare state, followed by a
// final test of the last value and a move of the result to the output register.
// A new item is taken once the previous result has left the engine, even while
// it still waits in the output register. Reset restores the register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [met_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0] cfg_data,
	met_pix_if.sink                        pixel,
	met_res_if.source                      result
);
	import met_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	met_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	met_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	met_dp u_dp (
		.clk        (clk),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.pixel_x    (pixel.pixel_x),
		.pixel_y    (pixel.pixel_y),
		.iterations (result.iterations),
		.inside_res (result.inside_res)
	);
endmodule

@@ sv/met_checker.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: port checker
// Watches the top-level channels for ordering and result consistency.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_macros.svh"

module met_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pixel_valid,
	input logic                       pixel_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [met_pkg::ITER_W-1:0] result_iterations,
	input logic                       result_inside_res
);
	import met_pkg::*;

	// The engine works on one item at a time.
	`MET_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pixel_valid && pixel_ready, !pixel_ready, "pixel accepted while engine busy")

	// A new result can only come from an item in progress.
	`MET_ASSERT_SAME(a_result_from_work, clk, arst_n, $rose(result_valid), !$past(pixel_ready), "result appeared from idle engine")

	// An escaped pixel counts fewer updates than the largest limit.
	`MET_ASSERT_SAME(a_escape_count, clk, arst_n, result_valid && !result_inside_res, result_iterations != '1, "escape count out of range")

	`MET_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_iterations) && $stable(result_inside_res), "stalled result changed")
endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.pixel_valid       (pixel.valid),
	.pixel_ready       (pixel.ready),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_iterations (result.iterations),
	.result_inside_res (result.inside_res)
);
